// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define PVM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define PVM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/pvm_pkg.sv =====
// types and constants of the planar vector math unit
package pvm_pkg;

   localparam int VEC_W      = 60;
   localparam int ROT_W      = 66;
   localparam int SQRT_STEPS = 32;
   localparam int TABLE_LEN  = 24;
   localparam int PRE_SHIFT  = 24;

   localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] SQRT2_Q30    = 32'd1518500250;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [30:0] SCALAR_TOP   = 31'h7FFF_FFFF;

   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [2:0] {
      OP_LENGTH    = 3'd0,
      OP_ANGLE     = 3'd1,
      OP_ANGLE_DIF = 3'd2,
      OP_NORMALIZE = 3'd3,
      OP_ROTATE    = 3'd4,
      OP_DISTANCE  = 3'd5
   } pvm_op_type;

   typedef struct packed {
      logic                    valid;
      pvm_op_type              op;
      logic                    za;
      logic                    zb;
      logic signed [VEC_W-1:0] x0;
      logic signed [VEC_W-1:0] y0;
      logic [31:0]             z0;
      logic signed [VEC_W-1:0] x1;
      logic signed [VEC_W-1:0] y1;
      logic [31:0]             z1;
      logic signed [ROT_W-1:0] rx;
      logic signed [ROT_W-1:0] ry;
      logic [31:0]             rz;
      logic                    mag_sat;
      logic [30:0]             ux;
      logic [30:0]             uy;
      logic [61:0]             sqa;
      logic [61:0]             sqb;
      logic [63:0]             rem;
      logic [63:0]             root;
   } pvm_stage_type;

endpackage

// ===== rtl/pvm_vec_cell.sv =====
// one vectoring step for both angle lanes
module pvm_vec_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  pvm_pkg::pvm_stage_type stage_in,
   output pvm_pkg::pvm_stage_type stage_out
);

   pvm_pkg::pvm_stage_type stage_ff;
   pvm_pkg::pvm_stage_type stage_in_n;

   always_comb begin
      stage_in_n = stage_in;
      if (!stage_in.y0[pvm_pkg::VEC_W-1]) begin
         stage_in_n.x0 = stage_in.x0 + (stage_in.y0 >>> STEP);
         stage_in_n.y0 = stage_in.y0 - (stage_in.x0 >>> STEP);
         stage_in_n.z0 = stage_in.z0 + pvm_pkg::ATAN_TABLE[STEP];
      end else begin
         stage_in_n.x0 = stage_in.x0 - (stage_in.y0 >>> STEP);
         stage_in_n.y0 = stage_in.y0 + (stage_in.x0 >>> STEP);
         stage_in_n.z0 = stage_in.z0 - pvm_pkg::ATAN_TABLE[STEP];
      end
      if (!stage_in.y1[pvm_pkg::VEC_W-1]) begin
         stage_in_n.x1 = stage_in.x1 + (stage_in.y1 >>> STEP);
         stage_in_n.y1 = stage_in.y1 - (stage_in.x1 >>> STEP);
         stage_in_n.z1 = stage_in.z1 + pvm_pkg::ATAN_TABLE[STEP];
      end else begin
         stage_in_n.x1 = stage_in.x1 - (stage_in.y1 >>> STEP);
         stage_in_n.y1 = stage_in.y1 + (stage_in.x1 >>> STEP);
         stage_in_n.z1 = stage_in.z1 - pvm_pkg::ATAN_TABLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in_n;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/pvm_rot_cell.sv =====
// one rotation step
module pvm_rot_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  pvm_pkg::pvm_stage_type stage_in,
   output pvm_pkg::pvm_stage_type stage_out
);

   pvm_pkg::pvm_stage_type stage_ff;
   pvm_pkg::pvm_stage_type stage_in_n;

   always_comb begin
      stage_in_n = stage_in;
      if (!stage_in.rz[31]) begin
         stage_in_n.rx = stage_in.rx - (stage_in.ry >>> STEP);
         stage_in_n.ry = stage_in.ry + (stage_in.rx >>> STEP);
         stage_in_n.rz = stage_in.rz - pvm_pkg::ATAN_TABLE[STEP];
      end else begin
         stage_in_n.rx = stage_in.rx + (stage_in.ry >>> STEP);
         stage_in_n.ry = stage_in.ry - (stage_in.rx >>> STEP);
         stage_in_n.rz = stage_in.rz + pvm_pkg::ATAN_TABLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in_n;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/pvm_sqrt_cell.sv =====
// one bit of the restoring integer square root
module pvm_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  pvm_pkg::pvm_stage_type stage_in,
   output pvm_pkg::pvm_stage_type stage_out
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   pvm_pkg::pvm_stage_type stage_ff;
   pvm_pkg::pvm_stage_type stage_in_n;
   logic [63:0]            trial;

   always_comb begin
      stage_in_n = stage_in;
      trial      = stage_in.root + BIT;
      if (stage_in.rem >= trial) begin
         stage_in_n.rem  = stage_in.rem - trial;
         stage_in_n.root = (stage_in.root >> 1) + BIT;
      end else begin
         stage_in_n.root = stage_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in_n;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/planar_vector_math_unit_core.sv =====
// planar vector math unit: cordic angle and rotation chains plus a square root chain
//
// Input transactions arrive on req_* (valid/ready): operation, vectors a and b and a
// rotation angle. Each produces exactly one rsp_* transaction with the vector, scalar,
// angle and saturation fields; fields an operation does not produce read zero.
// The datapath is one row of cells: an input stage, CORDIC_STEPS vectoring cells,
// CORDIC_STEPS rotation cells, 32 square root cells and an output register; every
// operation passes through all of them. A new transaction is taken every cycle
// unless the output stalls; the whole row advances together.
// When rsp_ready is low while a result is held, the row freezes and req_ready drops
// in the same cycle; items already inside are kept, none is lost.
// Synchronous reset empties the row: no result is shown until new transactions enter.
module planar_vector_math_unit_core #(
   parameter int CORDIC_STEPS  = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [15:0] req_rotate_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_x,
   output logic signed [31:0] rsp_result_y,
   output logic [30:0]        rsp_result_scalar,
   output logic signed [15:0] rsp_result_angle,
   output logic               rsp_saturated
);

   `include "assert_macros.svh"

   localparam int VW = pvm_pkg::VEC_W;
   localparam int RW = pvm_pkg::ROT_W;
   localparam int NS = pvm_pkg::SQRT_STEPS;
   localparam logic [31:0] SQRT2_Q = 32'(((64'(pvm_pkg::SQRT2_Q30))
      + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
   localparam logic signed [RW-1:0] NORM_X = RW'(pvm_pkg::INV_GAIN_Q30) <<< FRACTION_BITS;

   logic en;
   pvm_pkg::pvm_stage_type prep_in, prep_ff;
   pvm_pkg::pvm_stage_type vec_s [CORDIC_STEPS+1];
   pvm_pkg::pvm_stage_type rot_s [CORDIC_STEPS+1];
   pvm_pkg::pvm_stage_type sq_s  [NS+1];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [30:0]             res_s_ff, res_s_in;
   logic signed [15:0]      res_a_ff, res_a_in;
   logic                    res_sat_ff, res_sat_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // input stage
   logic signed [32:0] ax_e, ay_e, bx_e, by_e, dx, dy, adx, ady;
   always_comb begin
      ax_e = 33'(req_ax);
      ay_e = 33'(req_ay);
      bx_e = 33'(req_bx);
      by_e = 33'(req_by);
      prep_in       = '0;
      prep_in.valid = req_valid;
      prep_in.op    = pvm_pkg::pvm_op_type'(req_operation);
      prep_in.za    = (req_ax == 32'sd0) && (req_ay == 32'sd0);
      prep_in.zb    = (req_bx == 32'sd0) && (req_by == 32'sd0);
      if (req_ax < 0) begin
         prep_in.x0 = VW'(-ax_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.y0 = VW'(-ay_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.z0 = pvm_pkg::HALF_TURN;
      end else begin
         prep_in.x0 = VW'(ax_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.y0 = VW'(ay_e) <<< pvm_pkg::PRE_SHIFT;
      end
      if (req_bx < 0) begin
         prep_in.x1 = VW'(-bx_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.y1 = VW'(-by_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.z1 = pvm_pkg::HALF_TURN;
      end else begin
         prep_in.x1 = VW'(bx_e) <<< pvm_pkg::PRE_SHIFT;
         prep_in.y1 = VW'(by_e) <<< pvm_pkg::PRE_SHIFT;
      end
      prep_in.rx = RW'(req_ax) * RW'(pvm_pkg::INV_GAIN_Q30);
      prep_in.ry = RW'(req_ay) * RW'(pvm_pkg::INV_GAIN_Q30);
      prep_in.rz = {req_rotate_angle, 16'h0000};
      if (prep_in.op == pvm_pkg::OP_DISTANCE) begin
         dx = ax_e - bx_e;
         dy = ay_e - by_e;
      end else begin
         dx = ax_e;
         dy = ay_e;
      end
      adx = dx[32] ? -dx : dx;
      ady = dy[32] ? -dy : dy;
      prep_in.mag_sat = adx[32] || adx[31] || ady[32] || ady[31];
      prep_in.ux      = adx[30:0];
      prep_in.uy      = ady[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign vec_s[0] = prep_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      pvm_vec_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .stage_in(vec_s[i]), .stage_out(vec_s[i+1])
      );
   end

   // handoff into the rotation chain: normalize start vector, half turn fold, squares
   always_comb begin
      rot_s[0] = vec_s[CORDIC_STEPS];
      if (rot_s[0].op == pvm_pkg::OP_NORMALIZE) begin
         rot_s[0].rx = NORM_X;
         rot_s[0].ry = '0;
         rot_s[0].rz = vec_s[CORDIC_STEPS].za ? 32'h0 : vec_s[CORDIC_STEPS].z0;
      end
      if (rot_s[0].rz[31] != rot_s[0].rz[30]) begin
         rot_s[0].rx = -rot_s[0].rx;
         rot_s[0].ry = -rot_s[0].ry;
         rot_s[0].rz = rot_s[0].rz + pvm_pkg::HALF_TURN;
      end
      rot_s[0].sqa = 62'(rot_s[0].ux) * 62'(rot_s[0].ux);
      rot_s[0].sqb = 62'(rot_s[0].uy) * 62'(rot_s[0].uy);
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      pvm_rot_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .stage_in(rot_s[i]), .stage_out(rot_s[i+1])
      );
   end

   always_comb begin
      sq_s[0]      = rot_s[CORDIC_STEPS];
      sq_s[0].rem  = 64'(rot_s[CORDIC_STEPS].sqa) + 64'(rot_s[CORDIC_STEPS].sqb);
      sq_s[0].root = '0;
   end

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      pvm_sqrt_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .stage_in(sq_s[i]), .stage_out(sq_s[i+1])
      );
   end

   // result formatting
   pvm_pkg::pvm_stage_type fin;
   logic [63:0]            root_r;
   logic signed [RW-1:0]   tx, ty;
   logic signed [RW-31:0]  qx, qy;
   logic [31:0]            zdif, za0, zb1;
   logic                   sat_x, sat_y;

   always_comb begin
      fin    = sq_s[NS];
      root_r = (fin.rem > fin.root) ? fin.root + 64'd1 : fin.root;
      tx     = fin.rx + (RW'(1) <<< 29);
      ty     = fin.ry + (RW'(1) <<< 29);
      qx     = tx[RW-1:30];
      qy     = ty[RW-1:30];
      sat_x  = (qx > (RW-30)'(32'sh7FFF_FFFF)) || (qx < -((RW-30)'(33'sh0_8000_0000)));
      sat_y  = (qy > (RW-30)'(32'sh7FFF_FFFF)) || (qy < -((RW-30)'(33'sh0_8000_0000)));
      za0    = fin.za ? 32'h0 : fin.z0;
      zb1    = fin.zb ? 32'h0 : fin.z1;
      zdif   = za0 - zb1 + 32'h0000_8000;
      rsp_valid_in = fin.valid;
      res_x_in   = '0;
      res_y_in   = '0;
      res_s_in   = '0;
      res_a_in   = '0;
      res_sat_in = 1'b0;
      case (fin.op)
         pvm_pkg::OP_LENGTH, pvm_pkg::OP_DISTANCE: begin
            if (fin.mag_sat || (root_r > 64'(pvm_pkg::SCALAR_TOP))) begin
               res_s_in   = pvm_pkg::SCALAR_TOP;
               res_sat_in = 1'b1;
            end else begin
               res_s_in = root_r[30:0];
            end
         end
         pvm_pkg::OP_ANGLE: begin
            zdif     = za0 + 32'h0000_8000;
            res_a_in = zdif[31:16];
         end
         pvm_pkg::OP_ANGLE_DIF: begin
            res_a_in = zdif[31:16];
         end
         pvm_pkg::OP_NORMALIZE, pvm_pkg::OP_ROTATE: begin
            if ((fin.op == pvm_pkg::OP_NORMALIZE) && fin.za) begin
               res_x_in = SQRT2_Q;
               res_y_in = SQRT2_Q;
            end else begin
               res_x_in   = qx[RW-31] ? (sat_x ? 32'sh8000_0000 : qx[31:0])
                                      : (sat_x ? 32'sh7FFF_FFFF : qx[31:0]);
               res_y_in   = qy[RW-31] ? (sat_y ? 32'sh8000_0000 : qy[31:0])
                                      : (sat_y ? 32'sh7FFF_FFFF : qy[31:0]);
               res_sat_in = sat_x || sat_y;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_x_ff   <= res_x_in;
         res_y_ff   <= res_y_in;
         res_s_ff   <= res_s_in;
         res_a_ff   <= res_a_in;
         res_sat_ff <= res_sat_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_x      = res_x_ff;
   assign rsp_result_y      = res_y_ff;
   assign rsp_result_scalar = res_s_ff;
   assign rsp_result_angle  = res_a_ff;
   assign rsp_saturated     = res_sat_ff;

   `PVM_ASSERT(a_ready_follows_stall, req_ready == (!rsp_valid || rsp_ready),
      "input ready does not follow output stall")
   `PVM_ASSERT(a_hold_on_stall, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_x)
      && $stable(rsp_result_scalar), "result changed while stalled")
   `PVM_ASSERT(a_fields_exclusive, rsp_valid && (rsp_result_scalar != 31'd0)
      |-> (rsp_result_angle == 16'sd0) && (rsp_result_x == 32'sd0), "scalar with other fields")

endmodule

// ===== bench/tb_planar_vector_math_unit_core.sv =====
// self-checking bench for the planar vector math unit core
`timescale 1ns / 1ps

module tb_planar_vector_math_unit_core;

   localparam int STEPS = 16;
   localparam int FRAC = 16;
   localparam int TAIL_ITEMS = 200;
   localparam int RAND_ITEMS = 1430;
   localparam int DRAIN_CYCLES = 120;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] ax, ay, bx, by;
      logic signed [15:0] ang;
      bit                 hold;
   } vec_req_type;

   typedef struct {
      logic signed [31:0] rx, ry;
      logic [30:0]        scalar;
      logic signed [15:0] angle;
      logic               sat;
   } vec_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_operation = '0;
   logic signed [31:0] req_ax = '0, req_ay = '0, req_bx = '0, req_by = '0;
   logic signed [15:0] req_rotate_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_result_x, rsp_result_y;
   logic [30:0] rsp_result_scalar;
   logic signed [15:0] rsp_result_angle;
   logic rsp_saturated;

   vec_req_type pending_q[$];
   vec_rsp_type result_q[$];
   int errors = 0;
   bit stim_done = 0;
   longint cycles = 0;
   int send_gap = 0, recv_gap = 0;

   planar_vector_math_unit_core dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // vectoring: 32-bit binary angle of (x, y)
   function automatic logic [31:0] heading(input longint x, input longint y);
      logic [31:0] z = 0;
      longint nx;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = pvm_pkg::HALF_TURN;
      end
      x = x <<< pvm_pkg::PRE_SHIFT;
      y = y <<< pvm_pkg::PRE_SHIFT;
      for (int i = 0; i < STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + pvm_pkg::ATAN_TABLE[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - pvm_pkg::ATAN_TABLE[i];
         end
         x = nx;
      end
      return z;
   endfunction

   // rotation of a vector already scaled by 1/K with 30 extra fraction bits
   function automatic void turn(inout longint x, inout longint y, input logic [31:0] z);
      longint nx;
      if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
         x = -x;
         y = -y;
         z = z + pvm_pkg::HALF_TURN;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (!z[31]) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - pvm_pkg::ATAN_TABLE[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + pvm_pkg::ATAN_TABLE[i];
         end
         x = nx;
      end
   endfunction

   function automatic logic [31:0] round_clip(input longint v, inout logic sat);
      longint r = (v + (64'sd1 <<< 29)) >>> 30;
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647;
         sat = 1;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648;
         sat = 1;
      end
      return r[31:0];
   endfunction

   function automatic logic [30:0] hypot_fixed(input longint dx, input longint dy,
                                               inout logic sat);
      longint unsigned ux, uy, s, r, b;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ux = dx;
      uy = dy;
      if (ux > 64'h7FFF_FFFF || uy > 64'h7FFF_FFFF) begin
         sat = 1;
         return pvm_pkg::SCALAR_TOP;
      end
      s = ux * ux + uy * uy;
      ux = s;
      r = 0;
      b = 64'd1 << 62;
      while (b > ux) b = b >> 2;
      while (b != 0) begin
         if (ux >= r + b) begin
            ux = ux - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s - r * r > r) r++;
      if (r > 64'h7FFF_FFFF) begin
         sat = 1;
         return pvm_pkg::SCALAR_TOP;
      end
      return r[30:0];
   endfunction

   function automatic logic [15:0] to_angle16(input logic [31:0] z);
      logic [31:0] t = z + 32'h8000;
      return t[31:16];
   endfunction

   function automatic vec_rsp_type predict_math(input vec_req_type q);
      vec_rsp_type e = '{default: '0};
      longint x, y;
      case (q.op)
         pvm_pkg::OP_LENGTH: e.scalar = hypot_fixed(q.ax, q.ay, e.sat);
         pvm_pkg::OP_ANGLE: e.angle = to_angle16(heading(q.ax, q.ay));
         pvm_pkg::OP_ANGLE_DIF: e.angle = to_angle16(heading(q.ax, q.ay) -
                                                     heading(q.bx, q.by));
         pvm_pkg::OP_NORMALIZE: begin
            if (q.ax == 0 && q.ay == 0) begin
               x = (longint'(pvm_pkg::SQRT2_Q30) + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
               e.rx = x[31:0];
               e.ry = x[31:0];
            end else begin
               x = longint'(pvm_pkg::INV_GAIN_Q30) <<< FRAC;
               y = 0;
               turn(x, y, heading(q.ax, q.ay));
               e.rx = round_clip(x, e.sat);
               e.ry = round_clip(y, e.sat);
            end
         end
         pvm_pkg::OP_ROTATE: begin
            x = longint'(q.ax) * longint'(pvm_pkg::INV_GAIN_Q30);
            y = longint'(q.ay) * longint'(pvm_pkg::INV_GAIN_Q30);
            turn(x, y, {q.ang, 16'h0});
            e.rx = round_clip(x, e.sat);
            e.ry = round_clip(y, e.sat);
         end
         pvm_pkg::OP_DISTANCE: e.scalar = hypot_fixed(longint'(q.ax) - q.bx,
                                                      longint'(q.ay) - q.by, e.sat);
         default: ;
      endcase
      return e;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return -32'sh8000_0000;
         2: return 0;
         3: return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
         4: return $signed($urandom_range(0, 33554432)) - 16777216;
         default: return $urandom;
      endcase
   endfunction

   task automatic add(input logic [2:0] op, input logic signed [31:0] ax, ay, bx, by,
                      input logic signed [15:0] ang, input bit hold = 0);
      vec_req_type q;
      q.op = op;
      q.ax = ax;
      q.ay = ay;
      q.bx = bx;
      q.by = by;
      q.ang = ang;
      q.hold = hold;
      pending_q.push_back(q);
   endtask

   // driver: one transaction per handshake, random idle bursts
   always @(posedge clock) begin
      vec_req_type q;
      vec_req_type cur;
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            cur.op = req_operation;
            cur.ax = req_ax;
            cur.ay = req_ay;
            cur.bx = req_bx;
            cur.by = req_by;
            cur.ang = req_rotate_angle;
            result_q.push_back(predict_math(cur));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 12) - 1;
               req_valid <= 0;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].hold && (result_q.size() > 0 ||
                           (req_valid && req_ready)))) begin
               q = pending_q.pop_front();
               req_operation <= q.op;
               req_ax <= q.ax;
               req_ay <= q.ay;
               req_bx <= q.bx;
               req_by <= q.by;
               req_rotate_angle <= q.ang;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      vec_rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_result_x,
                        rsp_result_y);
            end else begin
               e = result_q.pop_front();
               if (rsp_result_x !== e.rx) begin
                  errors++;
                  $display("%0t: result_x exp %0d got %0d", $time, e.rx, rsp_result_x);
               end
               if (rsp_result_y !== e.ry) begin
                  errors++;
                  $display("%0t: result_y exp %0d got %0d", $time, e.ry, rsp_result_y);
               end
               if (rsp_result_scalar !== e.scalar) begin
                  errors++;
                  $display("%0t: result_scalar exp %0d got %0d", $time, e.scalar,
                           rsp_result_scalar);
               end
               if (rsp_result_angle !== e.angle) begin
                  errors++;
                  $display("%0t: result_angle exp %0d got %0d", $time, e.angle,
                           rsp_result_angle);
               end
               if (rsp_saturated !== e.sat) begin
                  errors++;
                  $display("%0t: saturated exp %0b got %0b", $time, e.sat, rsp_saturated);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 0;
         end else if (!stim_done && pending_q.size() > TAIL_ITEMS &&
                      $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 12) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_planar_vector_math_unit_core: done, errors");
         $finish;
      end
   end

   initial begin
      logic [2:0] op;
      int r;
      // directed corners
      add(pvm_pkg::OP_LENGTH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
      add(pvm_pkg::OP_LENGTH, -32'sh8000_0000, 0, 0, 0, 0);
      add(pvm_pkg::OP_LENGTH, 3 <<< 16, 4 <<< 16, 0, 0, 0);
      add(pvm_pkg::OP_ANGLE, 0, 0, 0, 0, 0);
      add(pvm_pkg::OP_ANGLE, -32'sh10000, 0, 0, 0, 0);
      add(pvm_pkg::OP_ANGLE, -32'sh8000_0000, -1, 0, 0, 0);
      add(pvm_pkg::OP_ANGLE, 0, -32'sh8000_0000, 0, 0, 0);
      add(pvm_pkg::OP_ANGLE_DIF, -32'sh10000, 1, -32'sh10000, -1, 0);
      add(pvm_pkg::OP_ANGLE_DIF, 32'sh7FFF_FFFF, 0, -32'sh8000_0000, 0, 0);
      add(pvm_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0);
      add(pvm_pkg::OP_NORMALIZE, -32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
      add(pvm_pkg::OP_NORMALIZE, 1, 0, 0, 0, 0);
      add(pvm_pkg::OP_ROTATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 16'sh2000);
      add(pvm_pkg::OP_ROTATE, -32'sh8000_0000, -32'sh8000_0000, 0, 0, -16'sh8000);
      add(pvm_pkg::OP_ROTATE, 32'sh10000, 0, 0, 0, 16'sh7FFF);
      add(pvm_pkg::OP_ROTATE, 32'sh10000, 32'sh10000, 0, 0, 16'sh4000);
      add(pvm_pkg::OP_ROTATE, 32'sh10000, 32'sh10000, 0, 0, -16'sh4000);
      add(pvm_pkg::OP_DISTANCE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
          -32'sh8000_0000, 0);
      add(pvm_pkg::OP_DISTANCE, 5, 7, 5, 7, 0);
      add(pvm_pkg::OP_DISTANCE, 32'sh4000_0000, 0, -32'sh3FFF_FFFF, 0, 0);
      add(OP_SPARE_A, 1, 2, 3, 4, 5);
      add(OP_SPARE_B, -1, -1, -1, -1, -1);
      for (int i = 0; i < RAND_ITEMS; i++) begin
         r = $urandom_range(0, 49);
         op = (r == 0) ? OP_SPARE_A : (r == 1) ? OP_SPARE_B : 3'($urandom_range(0, 5));
         add(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), 16'($urandom),
             i == RAND_ITEMS / 2);
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      while (pending_q.size() > 0 || req_valid || result_q.size() > 0) @(posedge clock);
      stim_done = 1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_planar_vector_math_unit_core: done, clean");
      end else begin
         $display("tb_planar_vector_math_unit_core: done, errors");
      end
      $finish;
   end

endmodule

// ===== planar_vector_math_unit_core.f =====
+incdir+rtl
rtl/pvm_pkg.sv
rtl/pvm_vec_cell.sv
rtl/pvm_rot_cell.sv
rtl/pvm_sqrt_cell.sv
rtl/planar_vector_math_unit_core.sv
bench/tb_planar_vector_math_unit_core.sv
